// ----- hw/rtl/fsip_pkg.sv -----
// fsip_pkg: types, character codes and widths shared by the integer printer
// depends on nothing; used by the channel interfaces, the controller, the
// datapath and the top level
package fsip_pkg;

  // field widths
  localparam int CHAR_W     = 8;
  localparam int ARG_W      = 32;
  localparam int WIDTH_W    = 6;
  localparam int NIB_W      = 4;
  localparam int MAX_DIGITS = 10;
  localparam int HEX_DIGITS = ARG_W / NIB_W;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(ARG_W);
  localparam int WPROD_W    = 10;

  // directive phase codes
  typedef logic [1:0] phase_t;
  localparam phase_t PH_TEXT  = 2'd0;
  localparam phase_t PH_PCT   = 2'd1;
  localparam phase_t PH_WIDTH = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE    = 8'h31;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_D      = 8'h64;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0] PAD_RESET = 8'h20;
  // 'a' - 10, added to a hex digit of ten or more
  localparam logic [CHAR_W-1:0] HEX_OFS   = 8'h57;

  // what a format character asks for in the current phase
  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_CHAR = 2'd1,
    K_DEC  = 2'd2,
    K_HEX  = 2'd3
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic parse;
    logic dec_start;
    logic hex_start;
    logic dab_step;
    logic count;
    logic emit_char;
    logic emit_pad;
    logic emit_digit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  dab_last;
    logic  pad_zero;
    logic  idx_zero;
    logic  out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/fsip_if.sv -----
// fsip_if: valid/ready channels for format words in and text words out
// depends on fsip_pkg for the field widths
interface fsip_in_if;
  logic                        valid;
  logic                        ready;
  logic [fsip_pkg::CHAR_W-1:0] fmt_char;
  logic [fsip_pkg::ARG_W-1:0]  arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

interface fsip_out_if;
  logic                        valid;
  logic                        ready;
  logic [fsip_pkg::CHAR_W-1:0] out_char;
  logic                        run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ----- hw/rtl/format_string_integer_printer_top.sv -----
// Integer printer for a minimal format language.
// Channels: in_chan (sink) takes one format word per handshake, fmt_char
// with arg_value, which is used only by a 'd' or 'x' conversion; out_chan
// (source) gives the text words, out_char with run_last high on the last
// word that one input word causes. Words that cause no text give nothing.
// An input word is taken only while the sequencer is idle; one output
// register sits on out_chan, so the next format word is taken while the
// last text word still waits.
// Text: a plain character or NUL is echoed as one text word; a directive
// character gives nothing. A 'x' or 'd' conversion gives its pad words and
// then its digits; a 'd' conversion first runs the 32-step shift-and-add-3
// converter that turns the argument into decimal one bit a cycle.
// Reset: synchronous, active high; returns to normal text with a space pad
// and width zero, and drops any word in the output register.
// Stall: while out_chan.ready is low the current word holds and the
// sequencer waits; nothing is lost.
// Depends on fsip_pkg, fsip_if, fsip_ctrl and fsip_dp.
module format_string_integer_printer_top #(
  parameter int MAX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  fsip_in_if.sink     in_chan,
  fsip_out_if.source  out_chan
);

  fsip_pkg::dp_cmd_t  cmd;
  fsip_pkg::dp_stat_t stat;
  logic               in_ready;

  // input handshake
  assign in_chan.ready = in_ready;

  // sequencer
  fsip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath
  fsip_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_fmt    (in_chan.fmt_char),
    .in_arg    (in_chan.arg_value),
    .out_char  (out_chan.out_char),
    .out_last  (out_chan.run_last),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready)
  );

endmodule

// ----- hw/rtl/fsip_ctrl.sv -----
// fsip_ctrl: sequencing state machine of the integer printer
// depends on fsip_pkg for the command and status structs
module fsip_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output fsip_pkg::dp_cmd_t  cmd,
  input  fsip_pkg::dp_stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_DABBLE = 7'b0000100,
    S_COUNT  = 7'b0001000,
    S_PAD    = 7'b0010000,
    S_DIGIT  = 7'b0100000,
    S_CHAR   = 7'b1000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.parse = 1'b1;
        unique case (stat.kind)
          fsip_pkg::K_NONE: state_next = S_IDLE;
          fsip_pkg::K_CHAR: state_next = S_CHAR;
          fsip_pkg::K_DEC: begin
            cmd.dec_start = 1'b1;
            state_next    = S_DABBLE;
          end
          fsip_pkg::K_HEX: begin
            cmd.hex_start = 1'b1;
            state_next    = S_COUNT;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DABBLE: begin
        cmd.dab_step = 1'b1;
        if (stat.dab_last) state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.count  = 1'b1;
        state_next = S_PAD;
      end
      S_PAD: begin
        if (stat.pad_zero) state_next = S_DIGIT;
        else if (stat.out_free) cmd.emit_pad = 1'b1;
      end
      S_DIGIT: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.idx_zero) state_next = S_IDLE;
        end
      end
      S_CHAR: begin
        if (stat.out_free) begin
          cmd.emit_char = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/fsip_dp.sv -----
// fsip_dp: directive registers, digit store with shift-and-add-3 converter,
// pad and digit counters and the output word register
// depends on fsip_pkg for widths, character codes and the control structs
module fsip_dp #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fsip_pkg::dp_cmd_t           cmd,
  output fsip_pkg::dp_stat_t          stat,
  input  logic [fsip_pkg::CHAR_W-1:0] in_fmt,
  input  logic [fsip_pkg::ARG_W-1:0]  in_arg,
  output logic [fsip_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last,
  output logic                        out_valid,
  input  logic                        out_ready
);

  localparam logic [fsip_pkg::WPROD_W-1:0] MAX_W = fsip_pkg::WPROD_W'(MAX_WIDTH);

  logic [fsip_pkg::CHAR_W-1:0]  fmt;
  logic [fsip_pkg::ARG_W-1:0]   bin;
  logic [fsip_pkg::NIB_W-1:0]   digit_store [fsip_pkg::MAX_DIGITS];
  logic [fsip_pkg::NIB_W-1:0]   dab_adj     [fsip_pkg::MAX_DIGITS];
  logic [fsip_pkg::CNT_W-1:0]   dab_cnt;
  fsip_pkg::phase_t             phase, phase_next;
  logic [fsip_pkg::CHAR_W-1:0]  pad, pad_next;
  logic [fsip_pkg::WIDTH_W-1:0] width, width_next;
  logic [fsip_pkg::WIDTH_W-1:0] pad_left;
  logic [fsip_pkg::IDX_W-1:0]   idx;
  logic [fsip_pkg::IDX_W-1:0]   n_digits;
  logic [fsip_pkg::WIDTH_W-1:0] n_wide;
  logic [fsip_pkg::WPROD_W-1:0] first_w, ext_w;
  logic [fsip_pkg::NIB_W-1:0]   cur_digit;
  logic [fsip_pkg::CHAR_W-1:0]  digit_char;
  fsip_pkg::kind_t              kind;
  logic                         is_conv, is_hex, is_digit, is_nz_digit;
  logic                         emit, last_digit;

  // character classes of the held format word
  assign is_hex      = (fmt == fsip_pkg::CH_X);
  assign is_conv     = (fmt == fsip_pkg::CH_D) || is_hex;
  assign is_digit    = (fmt >= fsip_pkg::CH_ZERO) && (fmt <= fsip_pkg::CH_NINE);
  assign is_nz_digit = (fmt >= fsip_pkg::CH_ONE) && (fmt <= fsip_pkg::CH_NINE);

  // what this word asks for
  always_comb begin
    kind = fsip_pkg::K_NONE;
    if (fmt == fsip_pkg::CH_NUL) begin
      kind = fsip_pkg::K_CHAR;
    end else begin
      unique case (phase)
        fsip_pkg::PH_PCT: begin
          if (is_conv) kind = is_hex ? fsip_pkg::K_HEX : fsip_pkg::K_DEC;
        end
        fsip_pkg::PH_WIDTH: begin
          if (!is_digit && is_conv)
            kind = is_hex ? fsip_pkg::K_HEX : fsip_pkg::K_DEC;
        end
        default: begin
          if (fmt != fsip_pkg::CH_PCT) kind = fsip_pkg::K_CHAR;
        end
      endcase
    end
  end

  assign stat.kind = kind;

  // width arithmetic: first digit, and width*10 + digit
  assign first_w = {{(fsip_pkg::WPROD_W - fsip_pkg::NIB_W){1'b0}},
                    fmt[fsip_pkg::NIB_W-1:0]};
  assign ext_w   = ({{(fsip_pkg::WPROD_W - fsip_pkg::WIDTH_W){1'b0}}, width} << 3)
                 + ({{(fsip_pkg::WPROD_W - fsip_pkg::WIDTH_W){1'b0}}, width} << 1)
                 + first_w;

  assign last_digit = cmd.emit_digit && (idx == '0);

  // directive phase, pad and width
  always_comb begin
    phase_next = phase;
    pad_next   = pad;
    width_next = width;
    if (last_digit) begin
      phase_next = fsip_pkg::PH_TEXT;
      pad_next   = fsip_pkg::PAD_RESET;
      width_next = '0;
    end else if (cmd.parse) begin
      if (fmt == fsip_pkg::CH_NUL) begin
        phase_next = fsip_pkg::PH_TEXT;
        pad_next   = fsip_pkg::PAD_RESET;
        width_next = '0;
      end else begin
        unique case (phase)
          fsip_pkg::PH_PCT: begin
            if (!is_conv) begin
              phase_next = fsip_pkg::PH_WIDTH;
              if (is_nz_digit)
                width_next = (first_w > MAX_W) ? MAX_W[fsip_pkg::WIDTH_W-1:0]
                                               : first_w[fsip_pkg::WIDTH_W-1:0];
              else
                pad_next = fmt;
            end
          end
          fsip_pkg::PH_WIDTH: begin
            if (is_digit) begin
              width_next = (ext_w > MAX_W) ? MAX_W[fsip_pkg::WIDTH_W-1:0]
                                           : ext_w[fsip_pkg::WIDTH_W-1:0];
            end else if (!is_conv) begin
              phase_next = fsip_pkg::PH_TEXT;
              pad_next   = fsip_pkg::PAD_RESET;
              width_next = '0;
            end
          end
          default: begin
            if (fmt == fsip_pkg::CH_PCT) begin
              phase_next = fsip_pkg::PH_PCT;
              pad_next   = fsip_pkg::PAD_RESET;
              width_next = '0;
            end else begin
              phase_next = fsip_pkg::PH_TEXT;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fsip_pkg::PH_TEXT;
      pad   <= fsip_pkg::PAD_RESET;
      width <= '0;
    end else begin
      phase <= phase_next;
      pad   <= pad_next;
      width <= width_next;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) fmt <= in_fmt;
  end

  // add 3 to every bcd digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < fsip_pkg::MAX_DIGITS; i++)
      dab_adj[i] = (digit_store[i] >= 4'd5) ? digit_store[i] + 4'd3 : digit_store[i];
  end

  // digit store: bcd shift register for 'd', plain nibbles for 'x'
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bin <= in_arg;
    end else if (cmd.dec_start) begin
      for (int i = 0; i < fsip_pkg::MAX_DIGITS; i++) digit_store[i] <= '0;
    end else if (cmd.hex_start) begin
      for (int i = 0; i < fsip_pkg::HEX_DIGITS; i++)
        digit_store[i] <= bin[i*fsip_pkg::NIB_W +: fsip_pkg::NIB_W];
      for (int i = fsip_pkg::HEX_DIGITS; i < fsip_pkg::MAX_DIGITS; i++)
        digit_store[i] <= '0;
    end else if (cmd.dab_step) begin
      digit_store[0] <= {dab_adj[0][fsip_pkg::NIB_W-2:0], bin[fsip_pkg::ARG_W-1]};
      for (int i = 1; i < fsip_pkg::MAX_DIGITS; i++)
        digit_store[i] <= {dab_adj[i][fsip_pkg::NIB_W-2:0], dab_adj[i-1][fsip_pkg::NIB_W-1]};
      bin <= {bin[fsip_pkg::ARG_W-2:0], 1'b0};
    end
  end

  // shift counter, wraps to zero after the last step
  always_ff @(posedge clk) begin
    if (rst || cmd.dec_start) dab_cnt <= '0;
    else if (cmd.dab_step)    dab_cnt <= dab_cnt + 1'b1;
  end

  assign stat.dab_last = (dab_cnt == '1);

  // number of significant digits, at least one
  always_comb begin
    n_digits = fsip_pkg::IDX_W'(1);
    for (int i = 1; i < fsip_pkg::MAX_DIGITS; i++)
      if (digit_store[i] != '0) n_digits = fsip_pkg::IDX_W'(i + 1);
  end

  assign n_wide = {{(fsip_pkg::WIDTH_W - fsip_pkg::IDX_W){1'b0}}, n_digits};

  // pad and digit counters
  always_ff @(posedge clk) begin
    if (cmd.count) begin
      pad_left <= (width > n_wide) ? width - n_wide : '0;
      idx      <= n_digits - 1'b1;
    end else begin
      if (cmd.emit_pad)   pad_left <= pad_left - 1'b1;
      if (cmd.emit_digit) idx      <= idx - 1'b1;
    end
  end

  assign stat.pad_zero = (pad_left == '0);
  assign stat.idx_zero = (idx == '0);

  // ascii of the current digit
  assign cur_digit  = digit_store[idx];
  assign digit_char = (cur_digit < 4'd10)
                    ? fsip_pkg::CH_ZERO + {{(fsip_pkg::CHAR_W - fsip_pkg::NIB_W){1'b0}}, cur_digit}
                    : fsip_pkg::HEX_OFS + {{(fsip_pkg::CHAR_W - fsip_pkg::NIB_W){1'b0}}, cur_digit};

  // output word register
  assign emit          = cmd.emit_char || cmd.emit_pad || cmd.emit_digit;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (emit)      out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      priority if (cmd.emit_char) begin
        out_char <= fmt;
        out_last <= 1'b1;
      end else if (cmd.emit_pad) begin
        out_char <= pad;
        out_last <= 1'b0;
      end else begin
        out_char <= digit_char;
        out_last <= (idx == '0);
      end
    end
  end

  // a word is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> stat.out_free)
    else $error("word loaded over an untaken word");

  // the last digit closes the directive
  a_dir_closed: assert property (@(posedge clk) disable iff (rst)
    last_digit |=> (phase == fsip_pkg::PH_TEXT) && (width == '0) &&
                   (pad == fsip_pkg::PAD_RESET))
    else $error("directive left open after conversion");

  // counting starts only once the shift sequence has wrapped
  a_count_wrapped: assert property (@(posedge clk) disable iff (rst)
    cmd.count |-> (dab_cnt == '0))
    else $error("digit count taken mid conversion");

  // pad words only while padding remains
  a_pad_left: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_pad |-> (pad_left != '0))
    else $error("pad word beyond the field width");

endmodule

// ----- dv/tb_format_string_integer_printer_top.sv -----
// tb_format_string_integer_printer_top: self-checking bench for the integer printer
// drives format words and checks every text word against a predictor kept here;
// depends on fsip_pkg, fsip_if and format_string_integer_printer_top
module tb_format_string_integer_printer_top;

  localparam int MAX_WIDTH = 32;

  typedef struct {
    logic [fsip_pkg::CHAR_W-1:0] out_char;
    logic                        run_last;
  } text_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fsip_in_if  in_chan ();
  fsip_out_if out_chan ();

  format_string_integer_printer_top #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  // predictor state
  fsip_pkg::phase_t            pred_phase;
  logic [fsip_pkg::CHAR_W-1:0] pred_pad;
  int                          pred_width;
  text_word_t                  text_q[$];

  // bookkeeping
  int  failures;
  int  mismatches;
  int  words_sent;
  int  words_checked;
  int  dec_convs;
  int  hex_convs;
  bit  steady;

  // directive over: back to plain text with default pad and width
  function automatic void clear_directive();
    pred_phase = fsip_pkg::PH_TEXT;
    pred_pad   = fsip_pkg::PAD_RESET;
    pred_width = 0;
  endfunction

  // expected text of one number, padded on the left to the field width
  function automatic void queue_number(input logic [fsip_pkg::ARG_W-1:0] arg, input bit hex);
    logic [fsip_pkg::NIB_W-1:0] digs[fsip_pkg::MAX_DIGITS];
    logic [fsip_pkg::ARG_W-1:0] v;
    int                         n;
    int                         base;
    text_word_t                 w;
    base = hex ? 16 : 10;
    v    = arg;
    n    = 0;
    do begin
      digs[n] = fsip_pkg::NIB_W'(v % base);
      n++;
      v = v / base;
    end while (v != 0 && n < fsip_pkg::MAX_DIGITS);
    for (int i = n; i < pred_width; i++) begin
      w.out_char = pred_pad;
      w.run_last = 1'b0;
      text_q.push_back(w);
    end
    for (int i = n - 1; i >= 0; i--) begin
      w.out_char = (digs[i] < 4'd10) ? fsip_pkg::CH_ZERO + fsip_pkg::CHAR_W'(digs[i])
                                     : fsip_pkg::HEX_OFS + fsip_pkg::CHAR_W'(digs[i]);
      w.run_last = (i == 0);
      text_q.push_back(w);
    end
    if (hex) hex_convs++;
    else dec_convs++;
    clear_directive();
  endfunction

  // expected text for one accepted format word
  function automatic void predict_text(input logic [fsip_pkg::CHAR_W-1:0] fmt,
                                       input logic [fsip_pkg::ARG_W-1:0] arg);
    text_word_t w;
    int         wd;
    if (fmt == fsip_pkg::CH_NUL) begin
      w.out_char = fsip_pkg::CH_NUL;
      w.run_last = 1'b1;
      text_q.push_back(w);
      clear_directive();
    end else if (pred_phase == fsip_pkg::PH_PCT) begin
      if (fmt == fsip_pkg::CH_D || fmt == fsip_pkg::CH_X) begin
        queue_number(arg, fmt == fsip_pkg::CH_X);
      end else begin
        if (fmt >= fsip_pkg::CH_ONE && fmt <= fsip_pkg::CH_NINE) begin
          wd = int'(fmt - fsip_pkg::CH_ZERO);
          pred_width = (wd > MAX_WIDTH) ? MAX_WIDTH : wd;
        end else begin
          pred_pad = fmt;
        end
        pred_phase = fsip_pkg::PH_WIDTH;
      end
    end else if (pred_phase == fsip_pkg::PH_WIDTH) begin
      if (fmt >= fsip_pkg::CH_ZERO && fmt <= fsip_pkg::CH_NINE) begin
        wd = pred_width * 10 + int'(fmt - fsip_pkg::CH_ZERO);
        pred_width = (wd > MAX_WIDTH) ? MAX_WIDTH : wd;
      end else if (fmt == fsip_pkg::CH_D || fmt == fsip_pkg::CH_X) begin
        queue_number(arg, fmt == fsip_pkg::CH_X);
      end else begin
        clear_directive();
      end
    end else if (fmt == fsip_pkg::CH_PCT) begin
      pred_phase = fsip_pkg::PH_PCT;
      pred_pad   = fsip_pkg::PAD_RESET;
      pred_width = 0;
    end else begin
      pred_phase = fsip_pkg::PH_TEXT;
      w.out_char = fmt;
      w.run_last = 1'b1;
      text_q.push_back(w);
    end
  endfunction

  // send one format word, predicting its text once it is taken
  task automatic send_word(input logic [fsip_pkg::CHAR_W-1:0] fmt,
                           input logic [fsip_pkg::ARG_W-1:0] arg);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, 4));
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.fmt_char  <= fmt;
    in_chan.arg_value <= arg;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predict_text(fmt, arg);
    words_sent++;
  endtask

  // argument mix: boundaries, small values and full-range values
  function automatic logic [fsip_pkg::ARG_W-1:0] draw_arg();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return fsip_pkg::ARG_W'($urandom_range(0, 999));
      3:       return 32'd999999999 + fsip_pkg::ARG_W'($urandom_range(0, 1));
      4:       return 32'h1 << $urandom_range(0, 31);
      5:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // one well-formed or slightly broken directive with random content
  task automatic send_directive(input logic [fsip_pkg::ARG_W-1:0] arg);
    logic [fsip_pkg::CHAR_W-1:0] ch;
    bit                          padded;
    int                          ndig;
    int                          pick;
    send_word(fsip_pkg::CH_PCT, $urandom);
    padded = 1'($urandom_range(0, 1));
    if (padded) begin
      do ch = fsip_pkg::CHAR_W'($urandom_range(1, 255));
      while ((ch >= fsip_pkg::CH_ONE && ch <= fsip_pkg::CH_NINE) ||
             ch == fsip_pkg::CH_D || ch == fsip_pkg::CH_X);
      send_word(ch, $urandom);
    end
    ndig = int'($urandom_range(0, 3));
    for (int i = 0; i < ndig; i++) begin
      if (i == 0 && !padded)
        ch = fsip_pkg::CHAR_W'($urandom_range(fsip_pkg::CH_ONE, fsip_pkg::CH_NINE));
      else
        ch = fsip_pkg::CHAR_W'($urandom_range(fsip_pkg::CH_ZERO, fsip_pkg::CH_NINE));
      send_word(ch, $urandom);
    end
    pick = int'($urandom_range(0, 19));
    if (pick < 16) begin
      ch = pick[0] ? fsip_pkg::CH_X : fsip_pkg::CH_D;
    end else if (pick < 18) begin
      ch = fsip_pkg::CH_NUL;
    end else begin
      // unknown conversion letter
      do ch = fsip_pkg::CHAR_W'($urandom_range(1, 255));
      while ((ch >= fsip_pkg::CH_ZERO && ch <= fsip_pkg::CH_NINE) ||
             ch == fsip_pkg::CH_D || ch == fsip_pkg::CH_X);
    end
    send_word(ch, arg);
  endtask

  // compare one taken text word with the oldest expectation
  task automatic check_word(input logic [fsip_pkg::CHAR_W-1:0] c, input logic last);
    text_word_t w;
    words_checked++;
    if (text_q.size() == 0) begin
      failures++;
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected text word: out_char %h run_last %b", c, last);
    end else begin
      w = text_q.pop_front();
      if (c !== w.out_char || last !== w.run_last) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("text word %0d: expected out_char %h run_last %b, got %h %b",
                   words_checked, w.out_char, w.run_last, c, last);
      end
    end
  endtask

  // text receiver with random back-pressure
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = steady ? 0 : int'($urandom_range(0, 4));
      repeat (stall) begin
        @(negedge clk);
        out_chan.ready <= 1'b0;
      end
      @(negedge clk);
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      check_word(out_chan.out_char, out_chan.run_last);
    end
  end

  // plain characters and the terminator
  task automatic test_plain_text();
    send_word(8'h01, 32'h0);
    send_word(8'hff, 32'hffffffff);
    send_word(fsip_pkg::CH_NUL, $urandom);
  endtask

  // bare conversions and zero-padded hex
  task automatic test_conversions();
    send_word(fsip_pkg::CH_PCT, 32'h0);
    send_word(fsip_pkg::CH_D, 32'h0);
    send_word(fsip_pkg::CH_PCT, 32'h0);
    send_word(fsip_pkg::CH_X, 32'hffffffff);
    send_word(fsip_pkg::CH_PCT, 32'h0);
    send_word(fsip_pkg::CH_ZERO, 32'h0);
    send_word(8'h38, 32'h0);
    send_word(fsip_pkg::CH_X, 32'h000000a5);
  endtask

  // percent as pad, width past the limit, width below the digit count
  task automatic test_padding();
    send_word(fsip_pkg::CH_PCT, 32'h0);
    send_word(fsip_pkg::CH_PCT, 32'h0);
    send_word(fsip_pkg::CH_NINE, 32'h0);
    send_word(fsip_pkg::CH_NINE, 32'h0);
    send_word(fsip_pkg::CH_D, 32'hffffffff);
    send_word(fsip_pkg::CH_PCT, 32'h0);
    send_word(8'h32, 32'h0);
    send_word(fsip_pkg::CH_D, 32'd123456);
  endtask

  // unknown conversion and terminator inside a directive
  task automatic test_broken_directives();
    send_word(fsip_pkg::CH_PCT, 32'h0);
    send_word(8'h35, 32'h0);
    send_word(8'h71, 32'hdeadbeef);
    send_word(fsip_pkg::CH_PCT, 32'h0);
    send_word(fsip_pkg::CH_NUL, 32'h0);
    send_word(fsip_pkg::CH_PCT, 32'h0);
    send_word(8'h37, 32'h0);
    send_word(fsip_pkg::CH_NUL, 32'h0);
  endtask

  // mostly directives, with text, terminators and noise mixed in
  task automatic test_random_format(input int count);
    int stop;
    int pick;
    stop = words_sent + count;
    while (words_sent < stop) begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      pick = int'($urandom_range(0, 9));
      if (pick < 6) begin
        send_directive(draw_arg());
      end else if (pick < 8) begin
        send_word(fsip_pkg::CHAR_W'($urandom_range(1, 255)), $urandom);
      end else if (pick == 8) begin
        send_word(fsip_pkg::CH_NUL, $urandom);
      end else begin
        repeat ($urandom_range(1, 3))
          send_word(fsip_pkg::CHAR_W'($urandom_range(0, 255)), $urandom);
      end
    end
    steady = 1'b0;
  endtask

  // back-to-back directives with no idling on either side
  task automatic test_back_to_back(input int count);
    int stop;
    stop   = words_sent + count;
    steady = 1'b1;
    while (words_sent < stop) send_directive(draw_arg());
    steady = 1'b0;
  endtask

  // run time limit
  initial begin
    #10800000;
    $display("tb_format_string_integer_printer_top: FAIL");
    $finish;
  end

  // main sequence
  initial begin
    in_chan.valid     = 1'b0;
    in_chan.fmt_char  = '0;
    in_chan.arg_value = '0;
    failures      = 0;
    mismatches    = 0;
    words_sent    = 0;
    words_checked = 0;
    dec_convs     = 0;
    hex_convs     = 0;
    steady        = 1'b0;
    clear_directive();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_plain_text();
    test_conversions();
    test_padding();
    test_broken_directives();
    test_random_format(360);
    test_back_to_back(60);

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d format words, checked %0d text words", words_sent, words_checked);
    $display("decimal conversions %0d, hex conversions %0d, mismatches %0d",
             dec_convs, hex_convs, mismatches);
    if (failures == 0) begin
      $display("tb_format_string_integer_printer_top: PASS");
    end else begin
      $display("tb_format_string_integer_printer_top: FAIL");
    end
    $finish;
  end

endmodule
